@@ hw/rtl/ims_pkg.sv @@
// ----------------------------------------------------------------------------
// ims_pkg
// Shared constants for the Ising Metropolis spin update block.
// ----------------------------------------------------------------------------
package ims_pkg;

	// Field widths fixed by the stream format
	localparam int COORD_W   = 6;
	localparam int RAND_W    = 32;
	localparam int MAGN_W    = 14;
	localparam int BOND_W    = 15;
	localparam int CFG_W     = 64;
	localparam int THR_W     = 32;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 32;

	// Acceptance threshold registers, one per neighbor sum
	localparam int NUM_REGS  = 5;
	localparam int REG_IDX_W = 3;
	localparam int NB_CNT_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_ACCEPT_NB_M4 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ACCEPT_NB_M2 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ACCEPT_NB_0  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ACCEPT_NB_P2 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ACCEPT_NB_P4 = 3'd4;

	// Request kinds
	localparam logic CMD_TRIAL = 1'b0;
	localparam logic CMD_SET   = 1'b1;

	typedef logic [NUM_REGS-1:0][CFG_W-1:0] accept_tbl_t;

endpackage

@@ hw/rtl/ims_front.sv @@
// ----------------------------------------------------------------------------
// ims_front
// Accepts requests, wraps the site onto the lattice, forms the four
// neighbor coordinates and queues the result for the execution side.
// ----------------------------------------------------------------------------
module ims_front #(
	parameter int LATTICE_SIDE = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          hold,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_cmd,
	input  logic [ims_pkg::COORD_W-1:0]   in_row,
	input  logic [ims_pkg::COORD_W-1:0]   in_col,
	input  logic [ims_pkg::RAND_W-1:0]    in_rand_word,
	input  logic                          in_spin_value,
	output logic                          q_valid,
	input  logic                          q_ready,
	output logic                          q_cmd,
	output logic [$clog2(LATTICE_SIDE)-1:0] q_row,
	output logic [$clog2(LATTICE_SIDE)-1:0] q_row_up,
	output logic [$clog2(LATTICE_SIDE)-1:0] q_row_dn,
	output logic [$clog2(LATTICE_SIDE)-1:0] q_col,
	output logic [$clog2(LATTICE_SIDE)-1:0] q_col_lf,
	output logic [$clog2(LATTICE_SIDE)-1:0] q_col_rt,
	output logic [ims_pkg::RAND_W-1:0]    q_rand_word,
	output logic                          q_spin_value
);

	localparam int RW     = $clog2(LATTICE_SIDE);
	localparam int QDEPTH = 2;
	localparam int COORDS = 1 << ims_pkg::COORD_W;

	typedef struct packed {
		logic                       cmd;
		logic [RW-1:0]              row;
		logic [RW-1:0]              row_up;
		logic [RW-1:0]              row_dn;
		logic [RW-1:0]              col;
		logic [RW-1:0]              col_lf;
		logic [RW-1:0]              col_rt;
		logic [ims_pkg::RAND_W-1:0] rand_word;
		logic                       spin_value;
	} entry_t;

	// Reduce a request coordinate modulo the lattice side (small table)
	function automatic logic [RW-1:0] wrap_coord(input logic [ims_pkg::COORD_W-1:0] v);
		logic [RW-1:0] r;
		r = '0;
		for (int i = 0; i < COORDS; i++) begin
			if (v == ims_pkg::COORD_W'(i)) begin
				r = RW'(i % LATTICE_SIDE);
			end
		end
		return r;
	endfunction

	function automatic logic [RW-1:0] step_dn(input logic [RW-1:0] v);
		return (v == '0) ? RW'(LATTICE_SIDE - 1) : v - RW'(1);
	endfunction

	function automatic logic [RW-1:0] step_up(input logic [RW-1:0] v);
		return (v == RW'(LATTICE_SIDE - 1)) ? '0 : v + RW'(1);
	endfunction

	entry_t        entry_d;
	entry_t        fifo_q [QDEPTH];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;
	logic [RW-1:0] row_w;
	logic [RW-1:0] col_w;
	entry_t        head;

	assign row_w = wrap_coord(in_row);
	assign col_w = wrap_coord(in_col);

	always_comb begin
		entry_d.cmd        = in_cmd;
		entry_d.row        = row_w;
		entry_d.row_up     = step_dn(row_w);
		entry_d.row_dn     = step_up(row_w);
		entry_d.col        = col_w;
		entry_d.col_lf     = step_dn(col_w);
		entry_d.col_rt     = step_up(col_w);
		entry_d.rand_word  = in_rand_word;
		entry_d.spin_value = in_spin_value;
	end

	assign in_ready = (count_q != 2'(QDEPTH)) && !hold;
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_valid  = (count_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head         = fifo_q[rd_ptr_q];
	assign q_cmd        = head.cmd;
	assign q_row        = head.row;
	assign q_row_up     = head.row_up;
	assign q_row_dn     = head.row_dn;
	assign q_col        = head.col;
	assign q_col_lf     = head.col_lf;
	assign q_col_rt     = head.col_rt;
	assign q_rand_word  = head.rand_word;
	assign q_spin_value = head.spin_value;

endmodule

@@ hw/rtl/ims_back.sv @@
// ----------------------------------------------------------------------------
// ims_back
// Executes queued requests against the lattice memory: reads the three rows
// around the site, decides the flip, writes the row back on a flip, updates
// the running sums and holds the result in an output register.
// ----------------------------------------------------------------------------
module ims_back #(
	parameter int LATTICE_SIDE = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ims_pkg::accept_tbl_t            accept_tbl,
	output logic                            clearing,
	input  logic                            q_valid,
	output logic                            q_ready,
	input  logic                            q_cmd,
	input  logic [$clog2(LATTICE_SIDE)-1:0] q_row,
	input  logic [$clog2(LATTICE_SIDE)-1:0] q_row_up,
	input  logic [$clog2(LATTICE_SIDE)-1:0] q_row_dn,
	input  logic [$clog2(LATTICE_SIDE)-1:0] q_col,
	input  logic [$clog2(LATTICE_SIDE)-1:0] q_col_lf,
	input  logic [$clog2(LATTICE_SIDE)-1:0] q_col_rt,
	input  logic [ims_pkg::RAND_W-1:0]      q_rand_word,
	input  logic                            q_spin_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            out_flipped,
	output logic                            out_spin_now,
	output logic [ims_pkg::MAGN_W-1:0]      out_magnetisation,
	output logic [ims_pkg::BOND_W-1:0]      out_bond_sum
);

	localparam int RW = $clog2(LATTICE_SIDE);
	localparam logic [ims_pkg::MAGN_W-1:0] MAGN_RST =
		ims_pkg::MAGN_W'(LATTICE_SIDE * LATTICE_SIDE);
	localparam logic [ims_pkg::BOND_W-1:0] BOND_RST =
		ims_pkg::BOND_W'(2 * LATTICE_SIDE * LATTICE_SIDE);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_RD_DN  = 3'd2;
	localparam logic [2:0] ST_RD_MID = 3'd3;
	localparam logic [2:0] ST_EXEC   = 3'd4;

	logic [LATTICE_SIDE-1:0] mem [LATTICE_SIDE];
	logic [LATTICE_SIDE-1:0] rdata_q;
	logic [LATTICE_SIDE-1:0] wdata;
	logic [RW-1:0]           addr;
	logic                    mem_we;
	logic                    mem_re;

	logic [2:0]                 state_q;
	logic [RW-1:0]              clr_q;
	logic                       cmd_q;
	logic [RW-1:0]              row_q;
	logic [RW-1:0]              row_dn_q;
	logic [RW-1:0]              col_q;
	logic [RW-1:0]              col_lf_q;
	logic [RW-1:0]              col_rt_q;
	logic [ims_pkg::RAND_W-1:0] rand_q;
	logic                       spin_val_q;
	logic                       nb_up_q;
	logic                       nb_dn_q;

	logic [ims_pkg::MAGN_W-1:0] magn_q;
	logic [ims_pkg::BOND_W-1:0] bond_q;
	logic                       out_valid_q;
	logic                       flipped_q;
	logic                       spin_now_q;

	logic                         s_cur;
	logic [ims_pkg::NB_CNT_W-1:0] nb_cnt;
	logic [ims_pkg::CFG_W-1:0]    acc_reg;
	logic [ims_pkg::THR_W-1:0]    thr;
	logic                         do_flip;
	logic                         exec_fire;
	logic [ims_pkg::BOND_W-1:0]   bond_delta;
	logic [ims_pkg::MAGN_W-1:0]   magn_next;
	logic [ims_pkg::BOND_W-1:0]   bond_next;

	assign clearing = (state_q == ST_CLEAR);
	assign q_ready  = (state_q == ST_IDLE);

	// Decide on the middle row, which is in the read register during EXEC
	assign s_cur   = rdata_q[col_q];
	assign nb_cnt  = ims_pkg::NB_CNT_W'(nb_up_q) + ims_pkg::NB_CNT_W'(nb_dn_q)
		+ ims_pkg::NB_CNT_W'(rdata_q[col_lf_q]) + ims_pkg::NB_CNT_W'(rdata_q[col_rt_q]);
	assign acc_reg = accept_tbl[nb_cnt];
	assign thr     = s_cur ? acc_reg[ims_pkg::THR_W-1:0]
		: acc_reg[ims_pkg::CFG_W-1:ims_pkg::THR_W];

	always_comb begin
		case (cmd_q)
			ims_pkg::CMD_SET: do_flip = (s_cur != spin_val_q);
			default:          do_flip = (rand_q <= thr);
		endcase
	end

	assign exec_fire = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	// Bond change for a flip is s * (8 - 4 * up_count)
	assign bond_delta = ims_pkg::BOND_W'(8) - (ims_pkg::BOND_W'(nb_cnt) << 2);
	assign magn_next  = s_cur ? magn_q - ims_pkg::MAGN_W'(2) : magn_q + ims_pkg::MAGN_W'(2);
	assign bond_next  = s_cur ? bond_q + bond_delta : bond_q - bond_delta;

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		addr   = row_q;
		wdata  = rdata_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				addr   = clr_q;
				wdata  = '1;
			end
			ST_IDLE: begin
				mem_re = q_valid;
				addr   = q_row_up;
			end
			ST_RD_DN: begin
				mem_re = 1'b1;
				addr   = row_dn_q;
			end
			ST_RD_MID: begin
				mem_re = 1'b1;
				addr   = row_q;
			end
			ST_EXEC: begin
				mem_we = exec_fire && do_flip;
				addr   = row_q;
				wdata  = rdata_q;
				wdata[col_q] = ~s_cur;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[addr];
		end
	end

	// Request payload and neighbor bits from the outer rows
	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			cmd_q      <= q_cmd;
			row_q      <= q_row;
			row_dn_q   <= q_row_dn;
			col_q      <= q_col;
			col_lf_q   <= q_col_lf;
			col_rt_q   <= q_col_rt;
			rand_q     <= q_rand_word;
			spin_val_q <= q_spin_value;
		end
		if (state_q == ST_RD_DN) begin
			nb_up_q <= rdata_q[col_q];
		end
		if (state_q == ST_RD_MID) begin
			nb_dn_q <= rdata_q[col_q];
		end
		if (exec_fire) begin
			flipped_q  <= do_flip;
			spin_now_q <= do_flip ? ~s_cur : s_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			magn_q      <= MAGN_RST;
			bond_q      <= BOND_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + RW'(1);
					if (clr_q == RW'(LATTICE_SIDE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_RD_DN;
					end
				end
				ST_RD_DN: begin
					state_q <= ST_RD_MID;
				end
				ST_RD_MID: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_fire) begin
						out_valid_q <= 1'b1;
						if (do_flip) begin
							magn_q <= magn_next;
							bond_q <= bond_next;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign out_flipped       = flipped_q;
	assign out_spin_now      = spin_now_q;
	assign out_magnetisation = magn_q;
	assign out_bond_sum      = bond_q;

	a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !(q_valid && q_ready))
		else $error("request taken during lattice clearing");

	a_result_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire |=> out_valid_q)
		else $error("executed request produced no result");

	a_sums_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!exec_fire |=> ($stable(magn_q) && $stable(bond_q)))
		else $error("running sums changed without an executed request");

	a_write_only_on_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !clearing) |-> (exec_fire && do_flip))
		else $error("lattice written without a flip");

endmodule

@@ hw/rtl/ising_metropolis_spin_update.sv @@
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// Metropolis spin update engine for a periodic square Ising lattice.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: tuser[0] is the kind (trial or set), tdata holds
//   row, column, random word and spin value. Each request yields exactly one
//   result on m_*: flipped flag, spin after the step, and the running
//   magnetisation and bond sum wrapped to 14 and 15 bits.
//   cfg_* writes the five acceptance threshold registers (index 0..4, other
//   indexes are dropped); write only while no request is outstanding.
//   The execution side serves one request at a time through the single
//   row-wide lattice memory port: three row reads and, on a flip, one write-back.
//   From acceptance to m_tvalid a request passes the queue, IDLE, RD_DN, RD_MID and EXEC.
//   A two-entry queue takes up to two more requests while a result waits on
//   m_tready; a stalled result holds and the execution side waits for it.
//   After reset every spin is up; a clearing pass writes the lattice one row
//   a cycle, with s_tready low until it ends.
//   Threshold registers reset to all ones, so every trial flips by default.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update #(
	parameter int LATTICE_SIDE = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [5:0] row, [11:6] col, [43:12] rand_word, [44] spin_value, rest zero
	input  logic [ims_pkg::S_TDATA_W-1:0]     s_tdata,
	// [0] cmd
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] flipped, [1] spin_now, [15:2] magnetisation, [30:16] bond_sum, rest zero
	output logic [ims_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ims_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [ims_pkg::CFG_W-1:0]         cfg_data
);

	localparam int RW = $clog2(LATTICE_SIDE);

	ims_pkg::accept_tbl_t accept_q;

	logic                       hold;
	logic                       q_valid;
	logic                       q_ready;
	logic                       q_cmd;
	logic [RW-1:0]              q_row;
	logic [RW-1:0]              q_row_up;
	logic [RW-1:0]              q_row_dn;
	logic [RW-1:0]              q_col;
	logic [RW-1:0]              q_col_lf;
	logic [RW-1:0]              q_col_rt;
	logic [ims_pkg::RAND_W-1:0] q_rand_word;
	logic                       q_spin_value;
	logic                       res_flipped;
	logic                       res_spin_now;
	logic [ims_pkg::MAGN_W-1:0] res_magn;
	logic [ims_pkg::BOND_W-1:0] res_bond;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ims_pkg::REG_ACCEPT_NB_M4: accept_q[ims_pkg::REG_ACCEPT_NB_M4] <= cfg_data;
				ims_pkg::REG_ACCEPT_NB_M2: accept_q[ims_pkg::REG_ACCEPT_NB_M2] <= cfg_data;
				ims_pkg::REG_ACCEPT_NB_0:  accept_q[ims_pkg::REG_ACCEPT_NB_0]  <= cfg_data;
				ims_pkg::REG_ACCEPT_NB_P2: accept_q[ims_pkg::REG_ACCEPT_NB_P2] <= cfg_data;
				ims_pkg::REG_ACCEPT_NB_P4: accept_q[ims_pkg::REG_ACCEPT_NB_P4] <= cfg_data;
				default: begin
					// drop writes beyond the register list
					accept_q <= accept_q;
				end
			endcase
		end
	end

	ims_front #(
		.LATTICE_SIDE (LATTICE_SIDE)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.hold          (hold),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_cmd        (s_tuser),
		.in_row        (s_tdata[5:0]),
		.in_col        (s_tdata[11:6]),
		.in_rand_word  (s_tdata[43:12]),
		.in_spin_value (s_tdata[44]),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_cmd         (q_cmd),
		.q_row         (q_row),
		.q_row_up      (q_row_up),
		.q_row_dn      (q_row_dn),
		.q_col         (q_col),
		.q_col_lf      (q_col_lf),
		.q_col_rt      (q_col_rt),
		.q_rand_word   (q_rand_word),
		.q_spin_value  (q_spin_value)
	);

	ims_back #(
		.LATTICE_SIDE (LATTICE_SIDE)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept_tbl        (accept_q),
		.clearing          (hold),
		.q_valid           (q_valid),
		.q_ready           (q_ready),
		.q_cmd             (q_cmd),
		.q_row             (q_row),
		.q_row_up          (q_row_up),
		.q_row_dn          (q_row_dn),
		.q_col             (q_col),
		.q_col_lf          (q_col_lf),
		.q_col_rt          (q_col_rt),
		.q_rand_word       (q_rand_word),
		.q_spin_value      (q_spin_value),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.out_flipped       (res_flipped),
		.out_spin_now      (res_spin_now),
		.out_magnetisation (res_magn),
		.out_bond_sum      (res_bond)
	);

	assign m_tdata = {1'b0, res_bond, res_magn, res_spin_now, res_flipped};

endmodule
